### hw/rtl/lmpe_pkg.sv
package lmpe_pkg;

   localparam int QTY_W         = 31;
   localparam int TRADE_PRICE_W = 32;
   localparam int PNL_W         = 64;
   localparam int POS_W         = 32;

   localparam logic MODE_FIFO = 1'b0;
   localparam logic MODE_LIFO = 1'b1;

   localparam logic SIDE_BUY  = 1'b0;
   localparam logic SIDE_SELL = 1'b1;

   typedef struct packed {
      logic                     trade_side;
      logic [QTY_W-1:0]         trade_quantity;
      logic [TRADE_PRICE_W-1:0] trade_price;
   } req_type;

   typedef struct packed {
      logic signed [PNL_W-1:0] realized_pnl;
      logic                    pnl_valid;
      logic signed [POS_W-1:0] net_position;
      logic                    store_full;
   } rsp_type;

endpackage

### hw/rtl/lot_matching_pnl_engine.sv
// Lot-matching position keeper with realized P&L.
// Request channel: start / busy with req_payload (side, quantity, price ticks).
// A request is taken at a clock edge where start is high and busy is low.
// Result channel: rsp_valid strobes for exactly one cycle with rsp_payload
// (realized P&L, pnl_valid, net position, store_full). Every request gives
// exactly one result. The receiver cannot stall; the result is gone after
// that one cycle.
// Configuration: csr_valid / csr_ready / csr_data writes the accounting mode
// (0 FIFO, 1 LIFO); csr_ready is always high. Write only while busy is low.
// Flow: open lots sit in one single-port-read, single-port-write memory with
// a registered read. An opening trade goes through the push state to the result
// strobe; a zero-quantity trade or one with no room left goes straight to the strobe. A
// closing trade walks lots from the front one at a time. For each lot touched:
// read, two partial products of the quantity times price difference, portion
// saturation, P&L sum. Then comes a push when the excess flips the position into
// a new lot, then the result. busy drops the cycle after the strobe.
// Reset: store empty, position flat, FIFO mode, no memory clearing pass.
module lot_matching_pnl_engine #(
   parameter int LOT_DEPTH   = 64,
   parameter int PRICE_WIDTH = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  lmpe_pkg::req_type req_payload,
   output logic              rsp_valid,
   output lmpe_pkg::rsp_type rsp_payload,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_data
);
   import lmpe_pkg::*;

   localparam int IDX_W     = (LOT_DEPTH > 1) ? $clog2(LOT_DEPTH) : 1;
   localparam int CNT_W     = $clog2(LOT_DEPTH + 1);
   localparam int LOT_W     = QTY_W + PRICE_WIDTH;
   localparam int HALF_W    = (PRICE_WIDTH + 1) / 2;
   localparam int HI_W      = PRICE_WIDTH - HALF_W;
   localparam int LO_PROD_W = QTY_W + HALF_W;
   localparam int HI_PROD_W = QTY_W + HI_W;
   localparam int PROD_W    = QTY_W + PRICE_WIDTH;
   localparam int CMP_W     = (PROD_W > PNL_W) ? PROD_W : PNL_W;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_READ   = 3'd1;
   localparam logic [2:0] ST_MUL_LO = 3'd2;
   localparam logic [2:0] ST_MUL_HI = 3'd3;
   localparam logic [2:0] ST_ACC    = 3'd4;
   localparam logic [2:0] ST_SUM    = 3'd5;
   localparam logic [2:0] ST_PUSH   = 3'd6;
   localparam logic [2:0] ST_RESULT = 3'd7;

   localparam logic signed [PNL_W-1:0] PNL_MAX = {1'b0, {(PNL_W-1){1'b1}}};
   localparam logic signed [PNL_W-1:0] PNL_MIN = {1'b1, {(PNL_W-1){1'b0}}};
   localparam logic signed [POS_W:0]   POS_LIMIT = {2'b00, {(POS_W-1){1'b1}}};

   // lot memory, each entry {quantity, price}
   logic [LOT_W-1:0] lot_mem [LOT_DEPTH];
   logic [LOT_W-1:0] rd_data_ff;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [LOT_W-1:0] wr_data;

   logic [2:0]               state_ff, state_in;
   logic                     mode_ff, mode_in;
   logic [IDX_W-1:0]         head_ff, head_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic signed [POS_W-1:0]  pos_ff, pos_in;
   logic                     side_ff, side_in;
   logic [PRICE_WIDTH-1:0]   price_ff, price_in;
   logic [QTY_W-1:0]         rem_ff, rem_in;
   logic [QTY_W-1:0]         take_ff, take_in;
   logic [QTY_W-1:0]         lot_qty_ff, lot_qty_in;
   logic [PRICE_WIDTH-1:0]   mag_ff, mag_in;
   logic                     neg_ff, neg_in;
   logic [LO_PROD_W-1:0]     prod_lo_ff, prod_lo_in;
   logic [HI_PROD_W-1:0]     prod_hi_ff, prod_hi_in;
   logic signed [PNL_W-1:0]  portion_ff, portion_in;
   logic signed [PNL_W-1:0]  pnl_ff, pnl_in;
   logic                     valid_ff, valid_in;
   logic                     full_ff, full_in;

   // combinational helpers
   logic [QTY_W-1:0]       lot_qty;
   logic [PRICE_WIDTH-1:0] lot_price;
   logic [PRICE_WIDTH-1:0] sell_px;
   logic [PRICE_WIDTH-1:0] buy_px;
   logic                   closing;
   logic signed [POS_W:0]  room;
   logic [QTY_W-1:0]       open_qty;
   logic [QTY_W-1:0]       req_qty;
   logic [PROD_W-1:0]      prod_full;
   logic [CMP_W-1:0]       prod_cmp;
   logic                   prod_sat;
   logic [PNL_W-2:0]       prod_mag;
   logic [PNL_W:0]         pnl_sum;
   logic [IDX_W:0]         tail_sum;
   logic [IDX_W-1:0]       tail_idx;
   logic [IDX_W-1:0]       head_inc;
   logic [IDX_W-1:0]       head_dec;
   logic signed [POS_W-1:0] take_delta;
   logic signed [POS_W-1:0] rem_delta;

   assign csr_ready = 1'b1;
   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_RESULT);

   always_comb begin
      rsp_payload.realized_pnl = pnl_ff;
      rsp_payload.pnl_valid    = valid_ff;
      rsp_payload.net_position = pos_ff;
      rsp_payload.store_full   = full_ff;
   end

   assign req_qty   = req_payload.trade_quantity;
   assign lot_qty   = rd_data_ff[LOT_W-1 -: QTY_W];
   assign lot_price = rd_data_ff[PRICE_WIDTH-1:0];
   assign sell_px   = (side_ff == SIDE_SELL) ? price_ff : lot_price;
   assign buy_px    = (side_ff == SIDE_SELL) ? lot_price : price_ff;

   assign closing = ((pos_ff > 0) && (req_payload.trade_side == SIDE_SELL)) ||
                    ((pos_ff < 0) && (req_payload.trade_side == SIDE_BUY));

   // room left before the position magnitude passes its limit
   always_comb begin
      if (req_payload.trade_side == SIDE_SELL) begin
         room = POS_LIMIT + (POS_W+1)'(pos_ff);
      end else begin
         room = POS_LIMIT - (POS_W+1)'(pos_ff);
      end
      if (room < 0) begin
         open_qty = '0;
      end else if ((POS_W+1)'(req_qty) > room) begin
         open_qty = room[QTY_W-1:0];
      end else begin
         open_qty = req_qty;
      end
   end

   // recombine partial products and saturate the portion
   assign prod_full = (PROD_W'(prod_hi_ff) << HALF_W) + PROD_W'(prod_lo_ff);
   assign prod_cmp  = CMP_W'(prod_full);
   assign prod_sat  = prod_cmp > CMP_W'(PNL_MAX);
   assign prod_mag  = prod_sat ? {(PNL_W-1){1'b1}} : prod_cmp[PNL_W-2:0];

   assign pnl_sum = {pnl_ff[PNL_W-1], pnl_ff} + {portion_ff[PNL_W-1], portion_ff};

   assign tail_sum = (IDX_W+1)'(head_ff) + (IDX_W+1)'(count_ff);
   assign tail_idx = (tail_sum >= (IDX_W+1)'(LOT_DEPTH)) ?
                     IDX_W'(tail_sum - (IDX_W+1)'(LOT_DEPTH)) : tail_sum[IDX_W-1:0];
   assign head_inc = (head_ff == IDX_W'(LOT_DEPTH - 1)) ? '0 : head_ff + 1'b1;
   assign head_dec = (head_ff == '0) ? IDX_W'(LOT_DEPTH - 1) : head_ff - 1'b1;

   assign take_delta = (side_ff == SIDE_SELL) ? -$signed({1'b0, take_ff})
                                              : $signed({1'b0, take_ff});
   assign rem_delta  = (side_ff == SIDE_SELL) ? -$signed({1'b0, rem_ff})
                                              : $signed({1'b0, rem_ff});

   always_comb begin
      state_in   = state_ff;
      mode_in    = mode_ff;
      head_in    = head_ff;
      count_in   = count_ff;
      pos_in     = pos_ff;
      side_in    = side_ff;
      price_in   = price_ff;
      rem_in     = rem_ff;
      take_in    = take_ff;
      lot_qty_in = lot_qty_ff;
      mag_in     = mag_ff;
      neg_in     = neg_ff;
      prod_lo_in = prod_lo_ff;
      prod_hi_in = prod_hi_ff;
      portion_in = portion_ff;
      pnl_in     = pnl_ff;
      valid_in   = valid_ff;
      full_in    = full_ff;
      wr_en      = 1'b0;
      wr_addr    = head_ff;
      wr_data    = {rem_ff, price_ff};

      if (csr_valid && csr_ready) begin
         mode_in = csr_data;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               side_in  = req_payload.trade_side;
               price_in = PRICE_WIDTH'(req_payload.trade_price);
               pnl_in   = '0;
               valid_in = 1'b0;
               full_in  = 1'b0;
               if (req_qty == '0) begin
                  state_in = ST_RESULT;
               end else if (closing) begin
                  // head lot read is already under way this cycle
                  rem_in   = req_qty;
                  state_in = ST_READ;
               end else if (open_qty == '0) begin
                  state_in = ST_RESULT;
               end else begin
                  rem_in   = open_qty;
                  state_in = ST_PUSH;
               end
            end
         end
         ST_READ: begin
            take_in    = (rem_ff < lot_qty) ? rem_ff : lot_qty;
            lot_qty_in = lot_qty;
            neg_in     = sell_px < buy_px;
            mag_in     = (sell_px < buy_px) ? buy_px - sell_px : sell_px - buy_px;
            state_in   = ST_MUL_LO;
         end
         ST_MUL_LO: begin
            prod_lo_in = LO_PROD_W'(take_ff) * LO_PROD_W'(mag_ff[HALF_W-1:0]);
            state_in   = ST_MUL_HI;
         end
         ST_MUL_HI: begin
            prod_hi_in = HI_PROD_W'(take_ff) * HI_PROD_W'(mag_ff[PRICE_WIDTH-1:HALF_W]);
            state_in   = ST_ACC;
         end
         ST_ACC: begin
            if (neg_ff) begin
               portion_in = prod_sat ? PNL_MIN : -$signed({1'b0, prod_mag});
            end else begin
               portion_in = $signed({1'b0, prod_mag});
            end
            rem_in = rem_ff - take_ff;
            pos_in = pos_ff + take_delta;
            if (take_ff == lot_qty_ff) begin
               head_in  = head_inc;
               count_in = count_ff - 1'b1;
            end else begin
               // partial fill leaves the rest of the lot at the front,
               // its price still held in the read register
               wr_en   = 1'b1;
               wr_addr = head_ff;
               wr_data = {lot_qty_ff - take_ff, lot_price};
            end
            state_in = ST_SUM;
         end
         ST_SUM: begin
            if (pnl_sum[PNL_W] != pnl_sum[PNL_W-1]) begin
               pnl_in = pnl_sum[PNL_W] ? PNL_MIN : PNL_MAX;
            end else begin
               pnl_in = $signed(pnl_sum[PNL_W-1:0]);
            end
            valid_in = 1'b1;
            priority if (rem_ff != '0 && count_ff != '0) begin
               state_in = ST_READ;
            end else if (rem_ff != '0) begin
               state_in = ST_PUSH;
            end else begin
               state_in = ST_RESULT;
            end
         end
         ST_PUSH: begin
            if (count_ff == CNT_W'(LOT_DEPTH)) begin
               full_in = 1'b1;
            end else begin
               wr_en    = 1'b1;
               wr_data  = {rem_ff, price_ff};
               count_in = count_ff + 1'b1;
               pos_in   = pos_ff + rem_delta;
               if (mode_ff == MODE_LIFO) begin
                  wr_addr = head_dec;
                  head_in = head_dec;
               end else begin
                  wr_addr = tail_idx;
               end
            end
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         lot_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= lot_mem[head_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         mode_ff  <= MODE_FIFO;
         head_ff  <= '0;
         count_ff <= '0;
         pos_ff   <= '0;
      end else begin
         state_ff <= state_in;
         mode_ff  <= mode_in;
         head_ff  <= head_in;
         count_ff <= count_in;
         pos_ff   <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      side_ff    <= side_in;
      price_ff   <= price_in;
      rem_ff     <= rem_in;
      take_ff    <= take_in;
      lot_qty_ff <= lot_qty_in;
      mag_ff     <= mag_in;
      neg_ff     <= neg_in;
      prod_lo_ff <= prod_lo_in;
      prod_hi_ff <= prod_hi_in;
      portion_ff <= portion_in;
      pnl_ff     <= pnl_in;
      valid_ff   <= valid_in;
      full_ff    <= full_in;
   end

endmodule

### bench/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import lmpe_pkg::*;

   localparam int     BOOK_DEPTH    = 64;
   localparam int     CYCLE_LIMIT   = 1_000_000;
   localparam int     DIRECTED_ROWS = 23;
   localparam int     DUE_DEPTH     = 8;
   localparam longint POS_CAP       = 64'sd2147483647;
   localparam longint PNL_MAX       = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam longint PNL_MIN       = 64'sh8000_0000_0000_0000;

   typedef enum logic {ROW_TRADE, ROW_MODE} row_kind_type;

   // pinned rows expect no fill and no drop, only the position is typed in
   typedef struct packed {
      row_kind_type            kind;
      logic                    mode;
      logic                    side;
      logic [QTY_W-1:0]        qty;
      logic [TRADE_PRICE_W-1:0] price;
      logic                    pinned;
      logic signed [POS_W-1:0] want_pos;
   } plan_row_type;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_payload;
   logic    rsp_valid;
   rsp_type rsp_payload;
   logic    csr_valid;
   logic    csr_ready;
   logic    csr_data;

   logic                    pin_flag;
   logic signed [POS_W-1:0] pin_pos;
   int                      sender_idle_pct;
   int                      cycle_count = 0;
   int                      mismatch_count = 0;

   // shadow of the lot book
   longint lot_qty   [BOOK_DEPTH];
   longint lot_price [BOOK_DEPTH];
   int     book_head = 0;
   int     book_count = 0;
   longint book_position = 0;
   logic   acct_mode = MODE_FIFO;

   // expected results in request order
   rsp_type due_ring [DUE_DEPTH];
   int      due_rd = 0;
   int      due_wr = 0;
   int      due_count = 0;

   plan_row_type trade_plan [DIRECTED_ROWS];

   lot_matching_pnl_engine #(
      .LOT_DEPTH   (BOOK_DEPTH),
      .PRICE_WIDTH (TRADE_PRICE_W)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   task automatic note_mismatch(string msg);
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
      mismatch_count++;
   endtask

   function automatic longint pnl_add(longint a, longint b);
      if (b > 0 && a > PNL_MAX - b) return PNL_MAX;
      if (b < 0 && a < PNL_MIN - b) return PNL_MIN;
      return a + b;
   endfunction

   // qty * (sell - buy), clamped to the signed 64-bit range
   function automatic longint fill_pnl(longint q, longint sp, longint bp);
      longint mag;
      bit     neg;
      neg = sp < bp;
      mag = neg ? bp - sp : sp - bp;
      if (q == 0 || mag == 0) return 0;
      if (mag > PNL_MAX / q) return neg ? PNL_MIN : PNL_MAX;
      return neg ? -(mag * q) : mag * q;
   endfunction

   function automatic bit book_push(longint q, longint p);
      int slot;
      if (book_count >= BOOK_DEPTH) return 1'b0;
      if (acct_mode == MODE_FIFO) begin
         slot = (book_head + book_count) % BOOK_DEPTH;
      end else begin
         book_head = (book_head + BOOK_DEPTH - 1) % BOOK_DEPTH;
         slot = book_head;
      end
      lot_qty[slot] = q;
      lot_price[slot] = p;
      book_count++;
      return 1'b1;
   endfunction

   function automatic rsp_type settle_trade(req_type t);
      rsp_type r;
      longint  qty, left, take, room, sp, bp, pnl, px;
      bit      sell, fill, dropped;
      sell = (t.trade_side == SIDE_SELL);
      qty = longint'(t.trade_quantity);
      px = longint'(t.trade_price);
      pnl = 0;
      fill = 1'b0;
      dropped = 1'b0;
      if (qty != 0) begin
         if ((book_position > 0 && sell) || (book_position < 0 && !sell)) begin
            left = qty;
            while (left > 0 && book_count > 0) begin
               take = (left < lot_qty[book_head]) ? left : lot_qty[book_head];
               sp = sell ? px : lot_price[book_head];
               bp = sell ? lot_price[book_head] : px;
               pnl = pnl_add(pnl, fill_pnl(take, sp, bp));
               fill = 1'b1;
               left -= take;
               book_position += sell ? -take : take;
               if (take == lot_qty[book_head]) begin
                  book_head = (book_head + 1) % BOOK_DEPTH;
                  book_count--;
               end else begin
                  lot_qty[book_head] -= take;
               end
            end
            // excess flips the position
            if (left > 0) begin
               if (book_push(left, px)) book_position = sell ? -left : left;
               else dropped = 1'b1;
            end
         end else begin
            room = sell ? POS_CAP + book_position : POS_CAP - book_position;
            if (room < 0) room = 0;
            if (qty > room) qty = room;
            if (qty > 0) begin
               if (book_push(qty, px)) book_position += sell ? -qty : qty;
               else dropped = 1'b1;
            end
         end
      end
      r.realized_pnl = pnl;
      r.pnl_valid = fill;
      r.net_position = book_position[31:0];
      r.store_full = dropped;
      return r;
   endfunction

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin : watch
      rsp_type want;
      if (!reset) begin
         if (rsp_valid) begin
            if (due_count == 0) begin
               note_mismatch("result with no request outstanding");
            end else begin
               want = due_ring[due_rd];
               due_rd = (due_rd + 1) % DUE_DEPTH;
               due_count--;
               if (rsp_payload.realized_pnl !== want.realized_pnl)
                  note_mismatch($sformatf("realized_pnl %0d, expected %0d",
                     rsp_payload.realized_pnl, want.realized_pnl));
               if (rsp_payload.pnl_valid !== want.pnl_valid)
                  note_mismatch($sformatf("pnl_valid %b, expected %b",
                     rsp_payload.pnl_valid, want.pnl_valid));
               if (rsp_payload.net_position !== want.net_position)
                  note_mismatch($sformatf("net_position %0d, expected %0d",
                     rsp_payload.net_position, want.net_position));
               if (rsp_payload.store_full !== want.store_full)
                  note_mismatch($sformatf("store_full %b, expected %b",
                     rsp_payload.store_full, want.store_full));
            end
         end
         if (start && !busy) begin
            want = settle_trade(req_payload);
            if (pin_flag) begin
               want.realized_pnl = '0;
               want.pnl_valid = 1'b0;
               want.net_position = pin_pos;
               want.store_full = 1'b0;
            end
            if (due_count == DUE_DEPTH) begin
               note_mismatch("too many requests without a result");
            end else begin
               due_ring[due_wr] = want;
               due_wr = (due_wr + 1) % DUE_DEPTH;
               due_count++;
            end
         end
         if (csr_valid && csr_ready) acct_mode = csr_data;
      end
   end

   // starts and ends at a falling edge
   task automatic send_trade(logic side, logic [QTY_W-1:0] qty,
                             logic [TRADE_PRICE_W-1:0] price, logic pinned,
                             logic signed [POS_W-1:0] want_pos);
      while ($urandom_range(99) < sender_idle_pct) begin
         start = 1'b0;
         @(negedge clock);
      end
      start = 1'b1;
      req_payload.trade_side = side;
      req_payload.trade_quantity = qty;
      req_payload.trade_price = price;
      pin_flag = pinned;
      pin_pos = want_pos;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   task automatic wait_quiet();
      start = 1'b0;
      while (due_count != 0 || busy) @(negedge clock);
      @(negedge clock);
   endtask

   task automatic set_accounting(logic mode);
      csr_valid = 1'b1;
      csr_data = mode;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   function automatic logic [TRADE_PRICE_W-1:0] pick_price();
      if ($urandom_range(3) == 0) return $urandom;
      return $urandom_range(900, 1100);
   endfunction

   task automatic run_stretch(int n);
      int     left, pick, burst;
      logic   side;
      longint mag, want;
      left = n;
      while (left > 0) begin
         pick = $urandom_range(99);
         if (pick < 3) wait_quiet();
         if (pick < 40) begin
            // run of opening trades, sometimes long enough to overflow the book
            if (book_position > 0) side = SIDE_BUY;
            else if (book_position < 0) side = SIDE_SELL;
            else side = 1'($urandom_range(1));
            burst = ($urandom_range(7) == 0) ? 70 : $urandom_range(1, 6);
            repeat (burst) send_trade(side, 31'($urandom_range(1, 1000)), pick_price(),
                                      1'b0, '0);
            left -= burst;
         end else if (pick < 75) begin
            mag = (book_position < 0) ? -book_position : book_position;
            if (mag == 0) begin
               side = 1'($urandom_range(1));
               want = longint'($urandom_range(1, 1000));
            end else begin
               side = (book_position > 0) ? SIDE_SELL : SIDE_BUY;
               case ($urandom_range(2))
                  0: want = (mag > 1) ? longint'($urandom_range(1, 32'(mag - 1))) : 1;
                  1: want = mag;
                  default: want = mag + longint'($urandom_range(1, 1000));
               endcase
               if (want > POS_CAP) want = POS_CAP;
            end
            send_trade(side, want[30:0], pick_price(), 1'b0, '0);
            left--;
         end else begin
            case ($urandom_range(3))
               0: want = 0;
               1: want = longint'($urandom);
               2: want = longint'($urandom_range(1, 5000));
               default: want = POS_CAP;
            endcase
            send_trade(1'($urandom_range(1)), want[30:0], $urandom, 1'b0, '0);
            left--;
         end
      end
   endtask

   initial begin
      trade_plan = '{
         '{ROW_TRADE, MODE_FIFO, SIDE_BUY,  31'd0,          32'hFFFF_FFFF, 1'b1, 32'sd0},
         '{ROW_TRADE, MODE_FIFO, SIDE_SELL, 31'd0,          32'd0,         1'b1, 32'sd0},
         '{ROW_TRADE, MODE_FIFO, SIDE_BUY,  31'd10,         32'd100,       1'b1, 32'sd10},
         '{ROW_TRADE, MODE_FIFO, SIDE_BUY,  31'd5,          32'd120,       1'b1, 32'sd15},
         '{ROW_TRADE, MODE_FIFO, SIDE_SELL, 31'd12,         32'd110,       1'b0, 32'sd0},
         '{ROW_TRADE, MODE_FIFO, SIDE_SELL, 31'd10,         32'd90,        1'b0, 32'sd0},
         '{ROW_TRADE, MODE_FIFO, SIDE_BUY,  31'd7,          32'd0,         1'b0, 32'sd0},
         '{ROW_TRADE, MODE_FIFO, SIDE_BUY,  31'h7FFF_FFFF,  32'd0,         1'b1, 32'sd2147483647},
         '{ROW_TRADE, MODE_FIFO, SIDE_BUY,  31'h7FFF_FFFF,  32'hFFFF_FFFF, 1'b1, 32'sd2147483647},
         '{ROW_TRADE, MODE_FIFO, SIDE_SELL, 31'h7FFF_FFFF,  32'hFFFF_FFFF, 1'b0, 32'sd0},
         '{ROW_TRADE, MODE_FIFO, SIDE_SELL, 31'h7FFF_FFFF,  32'd0,         1'b1, -32'sd2147483647},
         '{ROW_TRADE, MODE_FIFO, SIDE_SELL, 31'd1,          32'd5,         1'b1, -32'sd2147483647},
         '{ROW_TRADE, MODE_FIFO, SIDE_BUY,  31'h7FFF_FFFF,  32'hFFFF_FFFF, 1'b0, 32'sd0},
         '{ROW_MODE,  MODE_LIFO, SIDE_BUY,  31'd0,          32'd0,         1'b0, 32'sd0},
         '{ROW_TRADE, MODE_LIFO, SIDE_BUY,  31'd4,          32'd10,        1'b1, 32'sd4},
         '{ROW_TRADE, MODE_LIFO, SIDE_BUY,  31'd6,          32'd20,        1'b1, 32'sd10},
         '{ROW_TRADE, MODE_LIFO, SIDE_SELL, 31'd5,          32'd30,        1'b0, 32'sd0},
         '{ROW_TRADE, MODE_LIFO, SIDE_SELL, 31'd8,          32'd15,        1'b0, 32'sd0},
         '{ROW_TRADE, MODE_LIFO, SIDE_SELL, 31'd2,          32'hAAAA_AAAA, 1'b1, -32'sd5},
         '{ROW_TRADE, MODE_LIFO, SIDE_BUY,  31'd5,          32'h5555_5555, 1'b0, 32'sd0},
         '{ROW_MODE,  MODE_FIFO, SIDE_BUY,  31'd0,          32'd0,         1'b0, 32'sd0},
         '{ROW_TRADE, MODE_FIFO, SIDE_SELL, 31'd9,          32'd7,         1'b1, -32'sd9},
         '{ROW_TRADE, MODE_FIFO, SIDE_BUY,  31'd9,          32'd7,         1'b0, 32'sd0}
      };

      reset = 1'b1;
      start = 1'b0;
      req_payload = '0;
      csr_valid = 1'b0;
      csr_data = MODE_FIFO;
      pin_flag = 1'b0;
      pin_pos = '0;
      sender_idle_pct = 30;
      repeat (6) @(negedge clock);
      reset = 1'b0;

      foreach (trade_plan[i]) begin
         if (trade_plan[i].kind == ROW_MODE) begin
            wait_quiet();
            set_accounting(trade_plan[i].mode);
         end else begin
            send_trade(trade_plan[i].side, trade_plan[i].qty, trade_plan[i].price,
                       trade_plan[i].pinned, trade_plan[i].want_pos);
         end
      end

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: sender_idle_pct = 30;
            1: sender_idle_pct = 47;
            default: sender_idle_pct = 0;
         endcase
         for (int seg = 0; seg < 3; seg++) begin
            wait_quiet();
            set_accounting(((phase * 3 + seg) % 2 == 1) ? MODE_LIFO : MODE_FIFO);
            run_stretch(210);
         end
      end

      wait_quiet();
      repeat (20) @(negedge clock);
      if (due_count != 0)
         note_mismatch($sformatf("%0d results never arrived", due_count));
      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

### files.f
hw/rtl/lmpe_pkg.sv
hw/rtl/lot_matching_pnl_engine.sv
bench/tb.sv
